>>> rtl/core/nal_pkg.sv
// ----------------------------------------------------------------------------
// nal_pkg
// Shared widths, codes, root and divisor tables and fixed-point helpers of
// the normalised associated Legendre core.
// ----------------------------------------------------------------------------
`default_nettype none

package nal_pkg;

  localparam int MaxDegree = 7;
  localparam int Side      = MaxDegree + 1;
  localparam int DegW      = 3;
  localparam int AddrW     = 6;
  localparam int Depth     = Side * Side;
  localparam int EntryW    = 32;
  localparam int OpW       = 40;
  localparam int AccW      = 2 * OpW;
  localparam int MulSteps  = OpW / 8;
  localparam int RecipSh   = 40;
  localparam int DivW      = 9;
  localparam int CntW      = 6;
  localparam int LatW      = 18;
  localparam int OutW      = 28;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 3;

  localparam logic [CfgIdxW-1:0] CfgDegreeMax = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOrderMax  = 2'd1;

  localparam logic signed [OpW-1:0]    One28 = 40'sd268435456;
  localparam logic signed [EntryW-1:0] One24 = 32'sd16777216;

  localparam logic [63:0] Two40 = 64'h100_0000_0000;

  typedef enum logic {
    AluMul,
    AluDiv
  } alu_op_e;

  typedef struct packed {
    logic    go;
    alu_op_e op;
    logic    sh28;
  } alu_ctrl_t;

  // series divisors, index k-1
  localparam logic [DivW-1:0] DivSin [8] = '{9'd6, 9'd20, 9'd42, 9'd72,
                                             9'd110, 9'd156, 9'd210, 9'd272};
  localparam logic [DivW-1:0] DivCos [8] = '{9'd2, 9'd12, 9'd30, 9'd56,
                                             9'd90, 9'd132, 9'd182, 9'd240};

  typedef logic [31:0] root8_t  [Side];
  typedef logic [31:0] root64_t [Depth];

  // rounded-up reciprocal of a series divisor, scaled by 2^40
  function automatic logic [OpW-1:0] recip_div(logic [DivW-1:0] d);
    logic [OpW-1:0] r;
    case (d)
      9'd2:    r = OpW'((Two40 + 64'd1) / 64'd2);
      9'd6:    r = OpW'((Two40 + 64'd5) / 64'd6);
      9'd12:   r = OpW'((Two40 + 64'd11) / 64'd12);
      9'd20:   r = OpW'((Two40 + 64'd19) / 64'd20);
      9'd30:   r = OpW'((Two40 + 64'd29) / 64'd30);
      9'd42:   r = OpW'((Two40 + 64'd41) / 64'd42);
      9'd56:   r = OpW'((Two40 + 64'd55) / 64'd56);
      9'd72:   r = OpW'((Two40 + 64'd71) / 64'd72);
      9'd90:   r = OpW'((Two40 + 64'd89) / 64'd90);
      9'd110:  r = OpW'((Two40 + 64'd109) / 64'd110);
      9'd132:  r = OpW'((Two40 + 64'd131) / 64'd132);
      9'd156:  r = OpW'((Two40 + 64'd155) / 64'd156);
      9'd182:  r = OpW'((Two40 + 64'd181) / 64'd182);
      9'd210:  r = OpW'((Two40 + 64'd209) / 64'd210);
      9'd240:  r = OpW'((Two40 + 64'd239) / 64'd240);
      9'd272:  r = OpW'((Two40 + 64'd271) / 64'd272);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bv;
    v   = x;
    res = '0;
    bv  = 64'h1 << 62;
    while (bv > v) bv = bv >> 2;
    while (bv != 64'd0) begin
      if (v >= res + bv) begin
        v   = v - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] qroot(int num, int den);
    logic [63:0] r;
    r = isqrt64(udiv64(64'(num) << 48, 64'(den)));
    return r[31:0];
  endfunction

  function automatic root8_t build_sect();
    root8_t t;
    for (int d = 0; d < Side; d++) begin
      if (d == 0) t[d] = '0;
      else if (d == 1) t[d] = qroot(3, 1);
      else t[d] = qroot(2 * d + 1, 2 * d);
    end
    return t;
  endfunction

  function automatic root8_t build_sub();
    root8_t t;
    for (int d = 0; d < Side; d++) t[d] = qroot(2 * d + 1, 1);
    return t;
  endfunction

  function automatic root8_t build_b();
    root8_t t;
    for (int i = 0; i < Side; i++) t[i] = (i < 1) ? '0 : qroot(2 * i - 1, 1);
    return t;
  endfunction

  function automatic root64_t build_a();
    root64_t t;
    for (int i = 0; i < Side; i++) begin
      for (int j = 0; j < Side; j++) begin
        if (j + 2 <= i) t[i * Side + j] = qroot(2 * i + 1, (i - j) * (i + j));
        else t[i * Side + j] = '0;
      end
    end
    return t;
  endfunction

  function automatic root64_t build_e();
    root64_t t;
    for (int i = 0; i < Side; i++) begin
      for (int j = 0; j < Side; j++) begin
        if (j + 2 <= i) t[i * Side + j] = qroot((i + j - 1) * (i - j - 1), 2 * i - 3);
        else t[i * Side + j] = '0;
      end
    end
    return t;
  endfunction

  localparam root8_t  RootSect = build_sect();
  localparam root8_t  RootSub  = build_sub();
  localparam root8_t  RootB    = build_b();
  localparam root64_t RootA    = build_a();
  localparam root64_t RootE    = build_e();

  function automatic logic [AddrW-1:0] at_addr(logic [DegW-1:0] d, logic [DegW-1:0] o);
    return AddrW'(int'(d) * Side + int'(o));
  endfunction

  function automatic logic signed [OpW-1:0] ext40(logic signed [EntryW-1:0] v);
    return {{(OpW - EntryW){v[EntryW-1]}}, v};
  endfunction

  function automatic logic signed [OpW-1:0] coef40(logic [31:0] v);
    return {{(OpW - 32){1'b0}}, v};
  endfunction

  function automatic logic signed [EntryW-1:0] sat32(logic signed [OpW-1:0] v);
    logic signed [OpW-1:0] hi;
    logic signed [OpW-1:0] lo;
    hi = 40'sd2147483647;
    lo = -40'sd2147483648;
    if (v > hi) return 32'sh7FFFFFFF;
    if (v < lo) return 32'sh80000000;
    return v[EntryW-1:0];
  endfunction

  function automatic logic signed [OutW-1:0] out28(logic signed [EntryW-1:0] v);
    logic [EntryW:0] mag;
    logic [EntryW:0] rnd;
    logic [EntryW:0] neg;
    mag = v[EntryW-1] ? (~{v[EntryW-1], v} + 33'd1) : {1'b0, v};
    rnd = (mag + 33'd8) >> 4;
    neg = ~rnd + 33'd1;
    if (v[EntryW-1]) return neg[OutW-1:0];
    if (rnd > 33'h7FFFFFF) return 28'sh7FFFFFF;
    return rnd[OutW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/nal_ram.sv
// ----------------------------------------------------------------------------
// nal_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nal_ram #(
  parameter int Width = 64,
  parameter int Depth = 64,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/core/nal_alu.sv
// ----------------------------------------------------------------------------
// nal_alu
// Shared multi-cycle unit: signed multiply with rounding shift (8 bits per
// cycle) and rounded division by a series divisor, done as a multiply by
// its scaled reciprocal on the same datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module nal_alu import nal_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  alu_ctrl_t             ctrl_i,
  input  logic signed [OpW-1:0] a_i,
  input  logic signed [OpW-1:0] b_i,
  output logic                  done_o,
  output logic signed [OpW-1:0] res_o
);

  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_FIN
  } alu_st_e;

  alu_st_e           st_q;
  logic [CntW-1:0]   cnt_q;
  logic              neg_q;
  logic              sh28_q;
  logic              div_q;
  logic [OpW-1:0]    am_q;
  logic [OpW-1:0]    bm_q;
  logic [AccW-1:0]   acc_q;
  logic              done_q;
  logic signed [OpW-1:0] res_q;

  logic [OpW-1:0]    a_mag;
  logic [OpW-1:0]    b_mag;
  logic [OpW+7:0]    pp;
  logic [AccW-1:0]   acc_d;
  logic [AccW-1:0]   acc_rnd;
  logic [AccW-1:0]   acc_quo;
  logic [OpW-1:0]    mag;

  always_comb begin
    a_mag   = a_i[OpW-1] ? (~a_i + 1'b1) : a_i;
    b_mag   = b_i[OpW-1] ? (~b_i + 1'b1) : b_i;
    pp      = am_q * bm_q[7:0];
    acc_d   = acc_q + (AccW'(pp) << {cnt_q[2:0], 3'b000});
    if (sh28_q) begin
      acc_rnd = (acc_q + (AccW'(1) << 27)) >> 28;
    end else begin
      acc_rnd = (acc_q + (AccW'(1) << 23)) >> 24;
    end
    acc_quo = acc_q >> RecipSh;
    mag = div_q ? acc_quo[OpW-1:0] : acc_rnd[OpW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= A_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        A_IDLE: begin
          if (ctrl_i.go) begin
            cnt_q  <= '0;
            sh28_q <= ctrl_i.sh28;
            acc_q  <= '0;
            if (ctrl_i.op == AluDiv) begin
              div_q <= 1'b1;
              neg_q <= a_i[OpW-1];
              am_q  <= a_mag + OpW'(b_i[DivW-1:1]);
              bm_q  <= recip_div(b_i[DivW-1:0]);
            end else begin
              div_q <= 1'b0;
              neg_q <= a_i[OpW-1] ^ b_i[OpW-1];
              am_q  <= a_mag;
              bm_q  <= b_mag;
            end
            st_q <= A_MUL;
          end
        end
        A_MUL: begin
          acc_q <= acc_d;
          bm_q  <= bm_q >> 8;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(MulSteps - 1)) st_q <= A_FIN;
        end
        A_FIN: begin
          res_q  <= neg_q ? -$signed(mag) : $signed(mag);
          done_q <= 1'b1;
          st_q   <= A_IDLE;
        end
        default: st_q <= A_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

>>> rtl/core/normalized_associated_legendre_core.sv
// ----------------------------------------------------------------------------
// normalized_associated_legendre_core
// Fully normalised associated Legendre values and latitude derivatives.
// ----------------------------------------------------------------------------
// One latitude (Q.16 radians) is taken when start is high and busy is low.
// The core forms sine and cosine by a Horner series, fills a 64-entry table
// with the sectorial, subdiagonal and column recursions, and then emits the
// results in degree-major order, orders 0 to order_max, with last on the
// final one; results cannot be held off. Products and rounded divisions go
// through one shared unit: 34 operations for the series, 8 per degree for
// the sectorial terms and 9 per column entry. Registers are to be written
// only while busy is low; the core itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module normalized_associated_legendre_core import nal_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [LatW-1:0]     latitude_i,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_idx_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  output logic                       valid_o,
  output logic [DegW-1:0]            degree_o,
  output logic [DegW-1:0]            order_o,
  output logic signed [OutW-1:0]     value_o,
  output logic signed [OutW-1:0]     derivative_o,
  output logic                       last_o
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_X2,
    ST_TS_M,
    ST_TS_D,
    ST_TC_M,
    ST_TC_D,
    ST_SIN,
    ST_INIT,
    ST_SE_RD,
    ST_SE_LD,
    ST_SE_M1,
    ST_SE_M3,
    ST_SE_M2,
    ST_SE_M6,
    ST_SE_V0,
    ST_SE_D0,
    ST_SE_V1,
    ST_SE_D1,
    ST_CO_RD1,
    ST_CO_RD2,
    ST_CO_LD2,
    ST_CO_N1,
    ST_CO_N3,
    ST_CO_N4,
    ST_CO_V,
    ST_CO_E1,
    ST_CO_VA,
    ST_CO_D,
    ST_CO_E2,
    ST_CO_DA,
    ST_EM_RD,
    ST_EM_OUT
  } core_st_e;

  logic [DegW-1:0] dmax_q;
  logic [DegW-1:0] omax_q;

  core_st_e        state_q;
  logic            wait_q;
  logic            go_q;
  logic [DegW-1:0] nd_q;
  logic [DegW-1:0] no_q;
  logic [DegW-1:0] d_q;
  logic [DegW-1:0] i_q;
  logic [DegW-1:0] j_q;
  logic [2:0]      km1_q;

  logic signed [OpW-1:0]    x_q;
  logic signed [OpW-1:0]    x2_q;
  logic signed [OpW-1:0]    ts_q;
  logic signed [OpW-1:0]    tc_q;
  logic signed [OpW-1:0]    t1_q;
  logic signed [OpW-1:0]    t2_q;
  logic signed [OpW-1:0]    t3_q;
  logic signed [OpW-1:0]    t4_q;
  logic signed [EntryW-1:0] s_q;
  logic signed [EntryW-1:0] c_q;
  logic signed [EntryW-1:0] pp_q;
  logic signed [EntryW-1:0] dp_q;
  logic signed [EntryW-1:0] p2_q;
  logic signed [EntryW-1:0] d2_q;
  logic signed [EntryW-1:0] vt_q;

  logic                  valid_q;
  logic [DegW-1:0]       degree_q;
  logic [DegW-1:0]       order_q;
  logic signed [OutW-1:0] value_q;
  logic signed [OutW-1:0] deriv_q;
  logic                  last_q;

  alu_ctrl_t             alu_ctrl;
  alu_op_e               alu_op;
  logic                  alu_sh28;
  logic                  alu_use;
  logic signed [OpW-1:0] alu_a;
  logic signed [OpW-1:0] alu_b;
  logic                  alu_done;
  logic signed [OpW-1:0] alu_res;
  logic                  fire;

  logic                  ram_we;
  logic [AddrW-1:0]      ram_waddr;
  logic [2*EntryW-1:0]   ram_wdata;
  logic [AddrW-1:0]      ram_raddr;
  logic [2*EntryW-1:0]   ram_rdata;

  logic [AddrW-1:0]      ij_addr;

  assign fire    = wait_q && alu_done;
  assign ij_addr = at_addr(i_q, j_q);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dmax_q <= DegW'(MaxDegree);
      omax_q <= DegW'(MaxDegree);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDegreeMax: dmax_q <= cfg_data_i;
        CfgOrderMax:  omax_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // operand selection for the shared unit
  always_comb begin
    alu_use  = 1'b1;
    alu_op   = AluMul;
    alu_sh28 = 1'b1;
    alu_a    = '0;
    alu_b    = '0;
    case (state_q)
      ST_X2:    begin alu_a = x_q;  alu_b = x_q; end
      ST_TS_M:  begin alu_a = x2_q; alu_b = ts_q; end
      ST_TS_D:  begin
        alu_op = AluDiv; alu_a = t1_q; alu_b = OpW'(DivSin[km1_q]);
      end
      ST_TC_M:  begin alu_a = x2_q; alu_b = tc_q; end
      ST_TC_D:  begin
        alu_op = AluDiv; alu_a = t1_q; alu_b = OpW'(DivCos[km1_q]);
      end
      ST_SIN:   begin alu_a = x_q; alu_b = ts_q; end
      ST_SE_M1: begin alu_a = ext40(pp_q); alu_b = ext40(c_q); end
      ST_SE_M3: begin alu_a = ext40(pp_q); alu_b = ext40(s_q); end
      ST_SE_M2: begin alu_a = ext40(dp_q); alu_b = ext40(c_q); end
      ST_SE_M6: begin alu_a = ext40(dp_q); alu_b = ext40(s_q); end
      ST_SE_V0: begin
        alu_sh28 = 1'b0; alu_a = coef40(RootSect[d_q]); alu_b = t1_q;
      end
      ST_SE_D0: begin
        alu_sh28 = 1'b0; alu_a = coef40(RootSect[d_q]); alu_b = t3_q - t2_q;
      end
      ST_SE_V1: begin
        alu_sh28 = 1'b0; alu_a = coef40(RootSub[d_q]); alu_b = t2_q;
      end
      ST_SE_D1: begin
        alu_sh28 = 1'b0; alu_a = coef40(RootSub[d_q]); alu_b = t1_q + t4_q;
      end
      ST_CO_N1: begin alu_a = ext40(pp_q); alu_b = ext40(s_q); end
      ST_CO_N3: begin alu_a = ext40(dp_q); alu_b = ext40(s_q); end
      ST_CO_N4: begin alu_a = ext40(pp_q); alu_b = ext40(c_q); end
      ST_CO_V:  begin
        alu_sh28 = 1'b0; alu_a = coef40(RootB[i_q]); alu_b = t1_q;
      end
      ST_CO_E1: begin
        alu_sh28 = 1'b0; alu_a = coef40(RootE[ij_addr]); alu_b = ext40(p2_q);
      end
      ST_CO_VA: begin
        alu_sh28 = 1'b0; alu_a = coef40(RootA[ij_addr]); alu_b = t1_q - t4_q;
      end
      ST_CO_D:  begin
        alu_sh28 = 1'b0; alu_a = coef40(RootB[i_q]); alu_b = t2_q + t3_q;
      end
      ST_CO_E2: begin
        alu_sh28 = 1'b0; alu_a = coef40(RootE[ij_addr]); alu_b = ext40(d2_q);
      end
      ST_CO_DA: begin
        alu_sh28 = 1'b0; alu_a = coef40(RootA[ij_addr]); alu_b = t1_q - t4_q;
      end
      default: alu_use = 1'b0;
    endcase
  end

  assign alu_ctrl = '{go: go_q, op: alu_op, sh28: alu_sh28};

  // table ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = {vt_q, sat32(alu_res)};
    ram_raddr = '0;
    case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {One24, {EntryW{1'b0}}};
      end
      ST_SE_D0: begin
        ram_we    = fire;
        ram_waddr = at_addr(d_q, d_q);
      end
      ST_SE_D1: begin
        ram_we    = fire;
        ram_waddr = at_addr(d_q, d_q - 1'b1);
      end
      ST_CO_DA: begin
        ram_we    = fire;
        ram_waddr = ij_addr;
      end
      ST_SE_RD:  ram_raddr = at_addr(d_q - 1'b1, d_q - 1'b1);
      ST_CO_RD1: ram_raddr = at_addr(i_q - 1'b1, j_q);
      ST_CO_RD2: ram_raddr = at_addr(i_q - DegW'(2), j_q);
      ST_EM_RD:  ram_raddr = at_addr(d_q, j_q);
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wait_q  <= 1'b0;
      go_q    <= 1'b0;
      valid_q <= 1'b0;
      nd_q    <= '0;
      no_q    <= '0;
      d_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      km1_q   <= '0;
    end else begin
      go_q    <= 1'b0;
      valid_q <= 1'b0;
      if (alu_use && !wait_q) begin
        go_q   <= 1'b1;
        wait_q <= 1'b1;
      end
      if (fire) wait_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            nd_q    <= (dmax_q > DegW'(MaxDegree)) ? DegW'(MaxDegree) : dmax_q;
            no_q    <= (omax_q > DegW'(MaxDegree)) ? DegW'(MaxDegree) : omax_q;
            x_q     <= {{(OpW - LatW - 12){latitude_i[LatW-1]}}, latitude_i, 12'b0};
            ts_q    <= One28;
            tc_q    <= One28;
            km1_q   <= 3'd7;
            state_q <= ST_X2;
          end
        end
        ST_X2:   if (fire) begin x2_q <= alu_res; state_q <= ST_TS_M; end
        ST_TS_M: if (fire) begin t1_q <= alu_res; state_q <= ST_TS_D; end
        ST_TS_D: if (fire) begin ts_q <= One28 - alu_res; state_q <= ST_TC_M; end
        ST_TC_M: if (fire) begin t1_q <= alu_res; state_q <= ST_TC_D; end
        ST_TC_D: begin
          if (fire) begin
            tc_q <= One28 - alu_res;
            if (km1_q == 3'd0) begin
              state_q <= ST_SIN;
            end else begin
              km1_q   <= km1_q - 1'b1;
              state_q <= ST_TS_M;
            end
          end
        end
        ST_SIN: begin
          if (fire) begin
            s_q     <= sat32(alu_res);
            c_q     <= sat32(tc_q);
            state_q <= ST_INIT;
          end
        end
        ST_INIT: begin
          if (nd_q != '0) begin
            d_q     <= DegW'(1);
            state_q <= ST_SE_RD;
          end else begin
            d_q     <= '0;
            j_q     <= '0;
            state_q <= ST_EM_RD;
          end
        end
        ST_SE_RD: state_q <= ST_SE_LD;
        ST_SE_LD: begin
          pp_q    <= ram_rdata[2*EntryW-1:EntryW];
          dp_q    <= ram_rdata[EntryW-1:0];
          state_q <= ST_SE_M1;
        end
        ST_SE_M1: if (fire) begin t1_q <= alu_res; state_q <= ST_SE_M3; end
        ST_SE_M3: if (fire) begin t2_q <= alu_res; state_q <= ST_SE_M2; end
        ST_SE_M2: if (fire) begin t3_q <= alu_res; state_q <= ST_SE_M6; end
        ST_SE_M6: if (fire) begin t4_q <= alu_res; state_q <= ST_SE_V0; end
        ST_SE_V0: if (fire) begin vt_q <= sat32(alu_res); state_q <= ST_SE_D0; end
        ST_SE_D0: if (fire) state_q <= ST_SE_V1;
        ST_SE_V1: if (fire) begin vt_q <= sat32(alu_res); state_q <= ST_SE_D1; end
        ST_SE_D1: begin
          if (fire) begin
            if (d_q != nd_q) begin
              d_q     <= d_q + 1'b1;
              state_q <= ST_SE_RD;
            end else if (nd_q >= DegW'(2)) begin
              j_q     <= '0;
              i_q     <= DegW'(2);
              state_q <= ST_CO_RD1;
            end else begin
              d_q     <= '0;
              j_q     <= '0;
              state_q <= ST_EM_RD;
            end
          end
        end
        ST_CO_RD1: state_q <= ST_CO_RD2;
        ST_CO_RD2: begin
          pp_q    <= ram_rdata[2*EntryW-1:EntryW];
          dp_q    <= ram_rdata[EntryW-1:0];
          state_q <= ST_CO_LD2;
        end
        ST_CO_LD2: begin
          p2_q    <= ram_rdata[2*EntryW-1:EntryW];
          d2_q    <= ram_rdata[EntryW-1:0];
          state_q <= ST_CO_N1;
        end
        ST_CO_N1: if (fire) begin t1_q <= alu_res; state_q <= ST_CO_N3; end
        ST_CO_N3: if (fire) begin t2_q <= alu_res; state_q <= ST_CO_N4; end
        ST_CO_N4: if (fire) begin t3_q <= alu_res; state_q <= ST_CO_V; end
        ST_CO_V:  if (fire) begin t1_q <= alu_res; state_q <= ST_CO_E1; end
        ST_CO_E1: if (fire) begin t4_q <= alu_res; state_q <= ST_CO_VA; end
        ST_CO_VA: if (fire) begin vt_q <= sat32(alu_res); state_q <= ST_CO_D; end
        ST_CO_D:  if (fire) begin t1_q <= alu_res; state_q <= ST_CO_E2; end
        ST_CO_E2: if (fire) begin t4_q <= alu_res; state_q <= ST_CO_DA; end
        ST_CO_DA: begin
          if (fire) begin
            if (i_q != nd_q) begin
              i_q     <= i_q + 1'b1;
              state_q <= ST_CO_RD1;
            end else if (({1'b0, j_q} + 4'd3) <= {1'b0, nd_q}) begin
              j_q     <= j_q + 1'b1;
              i_q     <= j_q + 3'd3;
              state_q <= ST_CO_RD1;
            end else begin
              d_q     <= '0;
              j_q     <= '0;
              state_q <= ST_EM_RD;
            end
          end
        end
        ST_EM_RD: state_q <= ST_EM_OUT;
        ST_EM_OUT: begin
          valid_q  <= 1'b1;
          degree_q <= d_q;
          order_q  <= j_q;
          last_q   <= (d_q == nd_q) && (j_q == no_q);
          if (j_q <= d_q) begin
            value_q <= out28(ram_rdata[2*EntryW-1:EntryW]);
            deriv_q <= out28(ram_rdata[EntryW-1:0]);
          end else begin
            value_q <= '0;
            deriv_q <= '0;
          end
          if (j_q != no_q) begin
            j_q     <= j_q + 1'b1;
            state_q <= ST_EM_RD;
          end else if (d_q != nd_q) begin
            j_q     <= '0;
            d_q     <= d_q + 1'b1;
            state_q <= ST_EM_RD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  nal_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (alu_ctrl),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  nal_ram #(
    .Width (2 * EntryW),
    .Depth (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy         = (state_q != ST_IDLE);
  assign valid_o      = valid_q;
  assign degree_o     = degree_q;
  assign order_o      = order_q;
  assign value_o      = value_q;
  assign derivative_o = deriv_q;
  assign last_o       = last_q;

`ifndef ASSERT_OFF
  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (order_o <= no_q) && (degree_o <= nd_q))
    else $error("result indices beyond request limits");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !valid_o)
    else $error("result after last");

  a_alu_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> wait_q)
    else $error("unit finished without a pending operation");

  a_table_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != ST_IDLE))
    else $error("table written while idle");
`endif

endmodule

`default_nettype wire

>>> tb/normalized_associated_legendre_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normalized_associated_legendre_core_tb
// Self-checking bench for the normalised associated Legendre core.
// ----------------------------------------------------------------------------
// Latitude requests go in through the start/busy handshake, and the bench
// forms its own fixed-point sine, cosine and recursion table for each one.
// Every (degree, order) entry that the core strobes out is checked against
// the oldest predicted entry. The run covers directed extreme angles,
// sweeps of the degree and order limits, writes to unused register indexes
// and random angles with random idle bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module normalized_associated_legendre_core_tb;
  import nal_pkg::*;

  localparam longint CycleLimit = 3000000;

  typedef struct packed {
    logic [DegW-1:0]        deg;
    logic [DegW-1:0]        ord;
    logic signed [OutW-1:0] val;
    logic signed [OutW-1:0] der;
    logic                   fin;
  } legendre_entry_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic signed [LatW-1:0] latitude_i;
  logic                   cfg_we_i;
  logic [CfgIdxW-1:0]     cfg_idx_i;
  logic [CfgDataW-1:0]    cfg_data_i;
  logic                   valid_o;
  logic [DegW-1:0]        degree_o;
  logic [DegW-1:0]        order_o;
  logic signed [OutW-1:0] value_o;
  logic signed [OutW-1:0] derivative_o;
  logic                   last_o;

  legendre_entry_t pending_entries[$];
  logic [2:0]      degree_limit;
  logic [2:0]      order_limit;
  logic            idling_on;
  int              mismatches;
  int              requests_sent;
  int              entries_seen;
  longint          cycles;

  normalized_associated_legendre_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .latitude_i  (latitude_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .valid_o     (valid_o),
    .degree_o    (degree_o),
    .order_o     (order_o),
    .value_o     (value_o),
    .derivative_o(derivative_o),
    .last_o      (last_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic longint round_shift(longint p, int sh);
    longint half;
    half = longint'(1) << (sh - 1);
    if (p >= 0) return (p + half) >>> sh;
    return -((-p + half) >>> sh);
  endfunction

  function automatic longint mul_round(longint a, longint b, int sh);
    return round_shift(a * b, sh);
  endfunction

  function automatic longint div_nearest(longint p, longint d);
    if (p >= 0) return (p + d / 2) / d;
    return -((-p + d / 2) / d);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint clip32(longint v);
    return clip(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = v;
    root  = '0;
    probe = 64'h1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // sqrt(num/den) in q.24
  function automatic longint root_q24(longint num, longint den);
    logic [63:0] q;
    q = (64'(num) << 48) / 64'(den);
    return longint'(int_sqrt(q));
  endfunction

  function automatic logic signed [OutW-1:0] to_out(longint v);
    return OutW'(clip(round_shift(v, 4), -(64'sd1 <<< 27), (64'sd1 <<< 27) - 1));
  endfunction

  function automatic void compute_legendre_entries(logic signed [LatW-1:0] lat);
    longint x, x2, ts, tc, s, c, r, pp, dp, a, b, e, p1, p2, d1, d2, t;
    longint vt[64];
    longint dt[64];
    int nd, no, total, n;
    legendre_entry_t ent;
    nd = degree_limit;
    no = order_limit;
    x  = longint'(lat) * 4096;
    x2 = mul_round(x, x, 28);
    ts = 64'sd1 <<< 28;
    tc = 64'sd1 <<< 28;
    for (int k = 8; k >= 1; k--) begin
      ts = (64'sd1 <<< 28) - div_nearest(mul_round(x2, ts, 28), (2 * k) * (2 * k + 1));
      tc = (64'sd1 <<< 28) - div_nearest(mul_round(x2, tc, 28), (2 * k - 1) * (2 * k));
    end
    s = clip32(mul_round(x, ts, 28));
    c = clip32(tc);
    for (int i = 0; i < 64; i++) begin
      vt[i] = 0;
      dt[i] = 0;
    end
    vt[0] = 64'sd1 <<< 24;
    for (int d = 1; d <= nd; d++) begin
      pp = vt[(d - 1) * Side + d - 1];
      dp = dt[(d - 1) * Side + d - 1];
      r = (d == 1) ? root_q24(3, 1) : root_q24(2 * d + 1, 2 * d);
      vt[d * Side + d] = clip32(mul_round(r, mul_round(pp, c, 28), 24));
      dt[d * Side + d] = clip32(mul_round(r, mul_round(dp, c, 28) - mul_round(pp, s, 28), 24));
      r = root_q24(2 * d + 1, 1);
      vt[d * Side + d - 1] = clip32(mul_round(r, mul_round(pp, s, 28), 24));
      dt[d * Side + d - 1] =
        clip32(mul_round(r, mul_round(pp, c, 28) + mul_round(dp, s, 28), 24));
    end
    for (int j = 0; j + 2 <= nd; j++) begin
      for (int i = j + 2; i <= nd; i++) begin
        a  = root_q24(2 * i + 1, (i - j) * (i + j));
        b  = root_q24(2 * i - 1, 1);
        e  = root_q24((i + j - 1) * (i - j - 1), 2 * i - 3);
        p1 = vt[(i - 1) * Side + j];
        p2 = vt[(i - 2) * Side + j];
        d1 = dt[(i - 1) * Side + j];
        d2 = dt[(i - 2) * Side + j];
        t  = mul_round(b, mul_round(p1, s, 28), 24) - mul_round(e, p2, 24);
        vt[i * Side + j] = clip32(mul_round(a, t, 24));
        t  = mul_round(b, mul_round(d1, s, 28) + mul_round(p1, c, 28), 24)
             - mul_round(e, d2, 24);
        dt[i * Side + j] = clip32(mul_round(a, t, 24));
      end
    end
    total = (nd + 1) * (no + 1);
    n = 0;
    for (int d = 0; d <= nd; d++) begin
      for (int o = 0; o <= no; o++) begin
        n = n + 1;
        ent.deg = DegW'(d);
        ent.ord = DegW'(o);
        ent.val = (o <= d) ? to_out(vt[d * Side + o]) : '0;
        ent.der = (o <= d) ? to_out(dt[d * Side + o]) : '0;
        ent.fin = (n == total);
        pending_entries.push_back(ent);
      end
    end
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  always @(posedge clk_i) begin
    legendre_entry_t exp_ent;
    if (rst_ni && valid_o) begin
      entries_seen++;
      if (pending_entries.size() == 0) begin
        report_mismatch($sformatf("unexpected entry d=%0d o=%0d", degree_o, order_o));
      end else begin
        exp_ent = pending_entries.pop_front();
        if (degree_o !== exp_ent.deg || order_o !== exp_ent.ord)
          report_mismatch($sformatf("index got %0d,%0d exp %0d,%0d",
                                    degree_o, order_o, exp_ent.deg, exp_ent.ord));
        if (value_o !== exp_ent.val)
          report_mismatch($sformatf("value (%0d,%0d) got %0d exp %0d",
                                    exp_ent.deg, exp_ent.ord, value_o, exp_ent.val));
        if (derivative_o !== exp_ent.der)
          report_mismatch($sformatf("derivative (%0d,%0d) got %0d exp %0d",
                                    exp_ent.deg, exp_ent.ord, derivative_o, exp_ent.der));
        if (last_o !== exp_ent.fin)
          report_mismatch($sformatf("last (%0d,%0d) got %0b exp %0b",
                                    exp_ent.deg, exp_ent.ord, last_o, exp_ent.fin));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("** normalized_associated_legendre_core: FAILED **");
      $finish;
    end
  end

  // one latitude request, with an optional idle burst in front
  task automatic send_latitude(logic signed [LatW-1:0] lat);
    int gap;
    gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    latitude_i <= lat;
    start      <= 1'b1;
    do @(posedge clk_i); while (busy);
    compute_legendre_entries(lat);
    requests_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_entries.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgDegreeMax) degree_limit = data;
    else if (idx == CfgOrderMax) order_limit = data;
  endtask

  task automatic set_limits(logic [2:0] deg, logic [2:0] ord);
    write_reg(CfgDegreeMax, deg);
    write_reg(CfgOrderMax, ord);
  endtask

  task automatic test_extreme_angles();
    send_latitude(18'sd0);
    send_latitude(18'sd102944);
    send_latitude(-18'sd102944);
    send_latitude(18'sd131071);
    send_latitude(-18'sd131072);
    send_latitude(18'sd1);
    send_latitude(-18'sd1);
    send_latitude(18'sd51472);
    send_latitude(18'sh15555);
    send_latitude(18'sh2AAAA);
  endtask

  task automatic test_limit_sweep();
    set_limits(3'd0, 3'd0);
    send_latitude(18'sd40000);
    set_limits(3'd7, 3'd0);
    send_latitude(-18'sd70000);
    set_limits(3'd0, 3'd7);
    send_latitude(18'sd131071);
    set_limits(3'd2, 3'd6);
    send_latitude(-18'sd131072);
    set_limits(3'd6, 3'd2);
    send_latitude(18'sd90000);
    // unused indexes must leave the limits alone
    write_reg(CfgIdxW'(2), 3'd1);
    write_reg(CfgIdxW'(3), 3'd2);
    send_latitude(18'sd12345);
    set_limits(3'd7, 3'd7);
    send_latitude(-18'sd102944);
  endtask

  task automatic test_random_angles(int count);
    logic signed [LatW-1:0] lat;
    for (int k = 0; k < count; k++) begin
      if (k % 12 == 0) set_limits(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
      if (k == count - 40) idling_on = 1'b0;
      if ($urandom_range(0, 3) == 0) lat = LatW'($urandom);
      else lat = LatW'($signed($urandom_range(0, 205888)) - 102944);
      send_latitude(lat);
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    latitude_i   = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    degree_limit = 3'd7;
    order_limit  = 3'd7;
    idling_on    = 1'b1;
    mismatches   = 0;
    requests_sent = 0;
    entries_seen = 0;
    cycles       = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extreme_angles();
    test_limit_sweep();
    test_random_angles(290);
    drain();
    repeat (50) @(posedge clk_i);

    $display("requests %0d, entries checked %0d, limits swept 0..7, %0d cycles",
             requests_sent, entries_seen, cycles);
    $display("mismatches %0d, entries still pending %0d",
             mismatches, pending_entries.size());
    if (mismatches == 0 && pending_entries.size() == 0) begin
      $display("** normalized_associated_legendre_core: PASSED **");
    end else begin
      $display("** normalized_associated_legendre_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
